@@ design/pdsd_pkg.sv @@
// ----------------------------------------------------------------------------
// pdsd_pkg
// Shared types and constants of the pulse-distance sensor frame decoder:
// status codes, register indexes, packet layout and window checks.
// ----------------------------------------------------------------------------
package pdsd_pkg;

    // Status reported for every edge beat
    typedef enum logic [3:0] {
        ST_WAIT     = 4'd0,
        ST_START    = 4'd1,
        ST_HIGH_OK  = 4'd2,
        ST_BIT      = 4'd3,
        ST_PACKET   = 4'd4,
        ST_BAD_HIGH = 4'd5,
        ST_BAD_GAP  = 4'd6,
        ST_BAD_TEMP = 4'd7,
        ST_BAD_TYPE = 4'd8
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_HIGH_TOL = 2'd0;
    localparam logic [1:0] CFG_GAP_TOL  = 2'd1;
    localparam logic [1:0] CFG_SYNC_GAP = 2'd2;

    // Register reset values
    localparam logic [8:0]  HIGH_TOL_RESET = 9'd100;
    localparam logic [9:0]  GAP_TOL_RESET  = 10'd100;
    localparam logic [31:0] SYNC_GAP_RESET = 32'd8900;

    // Pulse and gap timing centers
    localparam logic [12:0] HIGH_CENTER = 13'd500;
    localparam logic [12:0] GAP0_CENTER = 13'd2000;
    localparam logic [12:0] GAP1_CENTER = 13'd4000;

    // Frame length and last bit index
    localparam int unsigned FRAME_BITS = 36;
    localparam logic [5:0]  LAST_BIT   = 6'(FRAME_BITS - 1);

    // Packet checks
    localparam logic signed [11:0] TEMP_MIN = -12'sd600;
    localparam logic signed [11:0] TEMP_MAX = 12'sd700;
    localparam logic [3:0]         TYPE_A   = 4'd5;
    localparam logic [3:0]         TYPE_B   = 4'd9;

    // Packet layout, last received bit at bit 0
    typedef struct packed {
        logic [3:0]         sensor_type;
        logic [7:0]         sensor_id;
        logic               batt_low;
        logic               spare;
        logic [1:0]         channel;
        logic signed [11:0] temperature;
        logic [7:0]         humidity;
    } packet_t;

    // Configuration register set
    typedef struct packed {
        logic [8:0]  high_tol;
        logic [9:0]  gap_tol;
        logic [31:0] sync_gap;
    } cfg_t;

    // One result beat
    typedef struct packed {
        status_t status;
        packet_t pkt;
    } result_t;

    // Check delta against center +/- tol; a negative lower bound clamps to zero
    function automatic logic in_window(logic [31:0] delta, logic [12:0] center,
                                       logic [9:0] tol);
        logic [12:0] tol_ext;
        logic        lo_ok;
        logic        hi_ok;
        tol_ext = 13'(tol);
        lo_ok   = (tol_ext >= center) || (delta >= 32'(center - tol_ext));
        hi_ok   = delta <= 32'(center + tol_ext);
        return lo_ok && hi_ok;
    endfunction

endpackage

@@ design/pdsd_packet_check.sv @@
// ----------------------------------------------------------------------------
// pdsd_packet_check
// Validate a complete packet: temperature range first, then sensor type.
// ----------------------------------------------------------------------------
module pdsd_packet_check (
    input  pdsd_pkg::packet_t pkt,
    output pdsd_pkg::status_t status
);

    logic temp_bad;
    logic type_ok;

    // Range-check temperature in tenths
    assign temp_bad = (pkt.temperature < pdsd_pkg::TEMP_MIN) ||
                      (pkt.temperature > pdsd_pkg::TEMP_MAX);

    // Accept only the two known sensor types
    assign type_ok = (pkt.sensor_type == pdsd_pkg::TYPE_A) ||
                     (pkt.sensor_type == pdsd_pkg::TYPE_B);

    always_comb begin
        priority if (temp_bad) begin
            status = pdsd_pkg::ST_BAD_TEMP;
        end else if (!type_ok) begin
            status = pdsd_pkg::ST_BAD_TYPE;
        end else begin
            status = pdsd_pkg::ST_PACKET;
        end
    end

endmodule

@@ design/pdsd_frame_rx.sv @@
// ----------------------------------------------------------------------------
// pdsd_frame_rx
// Frame receiver: holds edge time, receive flag, bit count and shift
// register, and works out the status of one edge in a single pass.
// ----------------------------------------------------------------------------
module pdsd_frame_rx #(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pdsd_pkg::cfg_t       cfg,
    input  logic                 step,
    input  logic                 edge_rising,
    input  logic [TIME_BITS-1:0] timestamp,
    output pdsd_pkg::result_t    result
);

    logic [TIME_BITS-1:0] previous_time_reg, previous_time_next;
    logic                 receiving_reg, receiving_next;
    logic [5:0]           bit_count_reg, bit_count_next;
    logic [35:0]          shift_bits_reg, shift_bits_next;

    logic [TIME_BITS-1:0] delta;
    logic [31:0]          delta_ext;
    logic                 high_ok;
    logic                 gap0_ok;
    logic                 gap1_ok;
    pdsd_pkg::packet_t    pkt_next;
    pdsd_pkg::status_t    check_status;

    // Elapsed time since the previous edge, modulo the timer width
    assign delta     = timestamp - previous_time_reg;
    assign delta_ext = 32'(delta);

    // Timing windows
    assign high_ok = pdsd_pkg::in_window(delta_ext, pdsd_pkg::HIGH_CENTER,
                                         10'(cfg.high_tol));
    assign gap0_ok = pdsd_pkg::in_window(delta_ext, pdsd_pkg::GAP0_CENTER, cfg.gap_tol);
    assign gap1_ok = pdsd_pkg::in_window(delta_ext, pdsd_pkg::GAP1_CENTER, cfg.gap_tol);

    // Check the packet as it would stand after this bit; a 0 wins on overlap
    assign pkt_next = pdsd_pkg::packet_t'({shift_bits_reg[34:0], !gap0_ok});

    pdsd_packet_check u_check (
        .pkt    (pkt_next),
        .status (check_status)
    );

    // Receiver decisions
    always_comb begin
        previous_time_next = timestamp;
        receiving_next     = receiving_reg;
        bit_count_next     = bit_count_reg;
        shift_bits_next    = shift_bits_reg;
        result.status      = pdsd_pkg::ST_WAIT;
        result.pkt         = '0;
        if (!receiving_reg) begin
            if (edge_rising && (delta_ext >= cfg.sync_gap)) begin
                receiving_next = 1'b1;
                bit_count_next = '0;
                result.status  = pdsd_pkg::ST_START;
            end
        end else if (!edge_rising) begin
            if (high_ok) begin
                result.status = pdsd_pkg::ST_HIGH_OK;
            end else begin
                receiving_next = 1'b0;
                bit_count_next = '0;
                result.status  = pdsd_pkg::ST_BAD_HIGH;
            end
        end else if (gap0_ok || gap1_ok) begin
            shift_bits_next = pkt_next;
            if (bit_count_reg == pdsd_pkg::LAST_BIT) begin
                // Frame complete: report and drop back to idle
                receiving_next = 1'b0;
                bit_count_next = '0;
                result.status  = check_status;
                if (check_status == pdsd_pkg::ST_PACKET) begin
                    result.pkt       = pkt_next;
                    result.pkt.spare = 1'b0;
                end
            end else begin
                bit_count_next = bit_count_reg + 6'd1;
                result.status  = pdsd_pkg::ST_BIT;
            end
        end else begin
            receiving_next = 1'b0;
            bit_count_next = '0;
            result.status  = pdsd_pkg::ST_BAD_GAP;
        end
    end

    // Commit state on each processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_time_reg <= '0;
            receiving_reg     <= 1'b0;
            bit_count_reg     <= '0;
            shift_bits_reg    <= '0;
        end else if (step) begin
            previous_time_reg <= previous_time_next;
            receiving_reg     <= receiving_next;
            bit_count_reg     <= bit_count_next;
            shift_bits_reg    <= shift_bits_next;
        end
    end

endmodule

@@ design/pulse_distance_sensor_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// pulse_distance_sensor_frame_decoder_unit
// Decodes pulse-distance coded weather sensor frames from radio edge
// timestamps and reports one status beat per edge.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_edge_rising, s_timestamp
//   m_        out        m_valid/m_ready    m_status, m_humidity, m_temperature,
//                                           m_channel, m_batt_low,
//                                           m_sensor_id, m_sensor_type
//   cfg_      in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// One edge beat per cycle is sustained while m_ready stays high. The result
// beat passes from the input register through the decode into the result
// register, and leaves from there once m_ready is high.
// The decode state updates in the same cycle as the result.
// aresetn is synchronous, active low, and restores register defaults.
// A stalled result holds the decode stage; the input register still takes
// one beat while it is empty, then s_ready stays low until m_ready returns.
// ----------------------------------------------------------------------------
module pulse_distance_sensor_frame_decoder_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_index,
    input  logic [31:0]        cfg_wr_data,
    // Edge input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_edge_rising,
    input  logic [31:0]        s_timestamp,
    // Status output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_status,
    output logic [7:0]         m_humidity,
    output logic signed [11:0] m_temperature,
    output logic [1:0]         m_channel,
    output logic               m_batt_low,
    output logic [7:0]         m_sensor_id,
    output logic [3:0]         m_sensor_type
);

    pdsd_pkg::cfg_t       cfg_reg;
    logic                 in_valid_reg;
    logic                 in_rising_reg;
    logic [TIME_BITS-1:0] in_time_reg;
    logic                 out_valid_reg;
    pdsd_pkg::result_t    out_result_reg;

    logic                 advance;
    logic                 step;
    pdsd_pkg::result_t    result;

    // Pipeline flow control
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_tol <= pdsd_pkg::HIGH_TOL_RESET;
            cfg_reg.gap_tol  <= pdsd_pkg::GAP_TOL_RESET;
            cfg_reg.sync_gap <= pdsd_pkg::SYNC_GAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                pdsd_pkg::CFG_HIGH_TOL: cfg_reg.high_tol <= cfg_wr_data[8:0];
                pdsd_pkg::CFG_GAP_TOL:  cfg_reg.gap_tol  <= cfg_wr_data[9:0];
                pdsd_pkg::CFG_SYNC_GAP: cfg_reg.sync_gap <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: capture a beat whenever the stage is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_rising_reg <= s_edge_rising;
            in_time_reg   <= s_timestamp[TIME_BITS-1:0];
        end
    end

    // Decode stage
    pdsd_frame_rx #(
        .TIME_BITS (TIME_BITS)
    ) u_frame_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .step        (step),
        .edge_rising (in_rising_reg),
        .timestamp   (in_time_reg),
        .result      (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_result_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_result_reg.status;
    assign m_humidity    = out_result_reg.pkt.humidity;
    assign m_temperature = out_result_reg.pkt.temperature;
    assign m_channel     = out_result_reg.pkt.channel;
    assign m_batt_low    = out_result_reg.pkt.batt_low;
    assign m_sensor_id   = out_result_reg.pkt.sensor_id;
    assign m_sensor_type = out_result_reg.pkt.sensor_type;

    // A processed beat always lands in the result register
    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("decoded beat did not reach the result register");

    // A full input stage that cannot drain must not take a new beat
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_ready)
        else $error("input register would be overwritten");

    // Non-packet results carry zero payload
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != pdsd_pkg::ST_PACKET)) |->
        (m_humidity == 8'd0 && m_temperature == 12'sd0 && m_channel == 2'd0 &&
         !m_batt_low && m_sensor_id == 8'd0 && m_sensor_type == 4'd0))
        else $error("payload not cleared on non-packet status");

    // Accepted packets pass the range and type checks
    a_packet_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == pdsd_pkg::ST_PACKET)) |->
        ((m_sensor_type == pdsd_pkg::TYPE_A || m_sensor_type == pdsd_pkg::TYPE_B) &&
         m_temperature >= pdsd_pkg::TEMP_MIN && m_temperature <= pdsd_pkg::TEMP_MAX))
        else $error("packet reported that fails its checks");

endmodule
